// ----- rtl/nmp_pkg.sv -----
// shared types and constants of the nv21 max-pool yuv packer
`timescale 1ns / 1ps
package nmp_pkg;

  localparam int PIX_W  = 8;
  localparam int POS_W  = 9;
  localparam int SIZE_W = 10;

  localparam logic [SIZE_W-1:0] OUT_WIDTH_RST  = 10'd320;
  localparam logic [SIZE_W-1:0] OUT_HEIGHT_RST = 10'd240;

  // register select taken from paddr bit 2
  localparam logic REG_OUT_WIDTH  = 1'b0;
  localparam logic REG_OUT_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_LUMA_SET,
    OP_LUMA_MAX,
    OP_EMIT
  } nmp_kind_t;

  typedef struct packed {
    nmp_kind_t        kind;
    logic [PIX_W-1:0] data_byte;
    logic [PIX_W-1:0] chroma_v;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             frame_end;
  } nmp_op_t;

endpackage

// ----- rtl/nmp_if.sv -----
// stream interfaces for the input byte channel and the pixel result channel
`timescale 1ns / 1ps
interface nmp_in_if import nmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] data_byte;
  logic             frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface nmp_out_if import nmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma;
  logic [PIX_W-1:0] chroma_u;
  logic [PIX_W-1:0] chroma_v;
  logic [POS_W-1:0] out_col;
  logic [POS_W-1:0] out_row;
  logic             frame_end;

  modport source (output valid, output luma, output chroma_u, output chroma_v,
                  output out_col, output out_row, output frame_end, input ready);
  modport sink (input valid, input luma, input chroma_u, input chroma_v,
                input out_col, input out_row, input frame_end, output ready);
endinterface

// ----- rtl/nv21_maxpool_yuv_pack.sv -----
// top level of the nv21 to half-scale yuv packer with 2x2 luma max pooling
`timescale 1ns / 1ps
// Takes one NV21 byte per cycle at full rate while the op queue is not full:
// luma plane first, then the V,U chroma plane; one pixel beat (pooled luma,
// U, V, column, row, frame end) leaves for every U byte. The front end tracks
// position and queues store ops in a four-entry queue; the back end does one
// read-modify-write of the pooled luma store per cycle unless output stalls,
// over a single write port and a registered read port, with forwarding of the
// previous write, and each result is held in the output register. The store
// needs no clearing pass. Sizes are set through the cfg port (out_width at 0,
// out_height at 4) and must only change while the block is idle.
module nv21_maxpool_yuv_pack import nmp_pkg::*; #(
  parameter int MAX_OUT_WIDTH  = 512,
  parameter int MAX_OUT_HEIGHT = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  nmp_in_if.sink      in_bus,
  nmp_out_if.source   out_bus,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW   = $clog2(MAX_OUT_WIDTH * MAX_OUT_HEIGHT);
  localparam int QD_W = AW + $bits(nmp_op_t);

  logic [SIZE_W-1:0] out_width_r, out_width_nxt;
  logic [SIZE_W-1:0] out_height_r, out_height_nxt;
  logic              cfg_wr;

  logic            q_push, q_pop, q_full, q_empty;
  nmp_op_t         f_op, b_op;
  logic [AW-1:0]   f_addr, b_addr;
  logic [QD_W-1:0] q_rd_data;

  // config registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    out_width_nxt  = out_width_r;
    out_height_nxt = out_height_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_OUT_WIDTH:  out_width_nxt  = cfg_pwdata[SIZE_W-1:0];
        REG_OUT_HEIGHT: out_height_nxt = cfg_pwdata[SIZE_W-1:0];
        default:        out_width_nxt  = out_width_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_OUT_WIDTH:  cfg_prdata = 32'(out_width_r);
      REG_OUT_HEIGHT: cfg_prdata = 32'(out_height_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= OUT_WIDTH_RST;
      out_height_r <= OUT_HEIGHT_RST;
    end else begin
      out_width_r  <= out_width_nxt;
      out_height_r <= out_height_nxt;
    end
  end

  nmp_front #(
    .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
    .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT),
    .AW             (AW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_out_width  (out_width_r),
    .cfg_out_height (out_height_r),
    .in_bus         (in_bus),
    .q_push         (q_push),
    .q_op           (f_op),
    .q_addr         (f_addr),
    .q_full         (q_full)
  );

  nmp_fifo #(
    .DATA_W (QD_W),
    .DEPTH  (4)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data ({f_addr, f_op}),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  assign b_addr = q_rd_data[QD_W-1:$bits(nmp_op_t)];
  assign b_op   = q_rd_data[$bits(nmp_op_t)-1:0];

  nmp_back #(
    .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
    .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT),
    .AW             (AW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_empty),
    .q_op    (b_op),
    .q_addr  (b_addr),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("op pushed into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("op popped from empty queue");

  a_frame_start_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.frame_start) |=> !q_empty)
    else $error("frame start beat did not reach the queue");
`endif

endmodule

// ----- rtl/nmp_front.sv -----
// front end: position counters, plane tracking, v hold and op classification
`timescale 1ns / 1ps
module nmp_front import nmp_pkg::*; #(
  parameter int MAX_OUT_WIDTH  = 512,
  parameter int MAX_OUT_HEIGHT = 512,
  parameter int AW             = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] cfg_out_width,
  input  logic [SIZE_W-1:0] cfg_out_height,
  nmp_in_if.sink            in_bus,
  output logic              q_push,
  output nmp_op_t           q_op,
  output logic [AW-1:0]     q_addr,
  input  logic              q_full
);

  localparam int WV_W = $clog2(MAX_OUT_WIDTH + 1);
  localparam int HV_W = $clog2(MAX_OUT_HEIGHT + 1);
  localparam int CW   = WV_W + 1;
  localparam int RW   = HV_W + 1;

  logic [WV_W-1:0] w_eff;
  logic [HV_W-1:0] h_eff;
  logic [CW-1:0]   two_w;
  logic [RW-1:0]   two_h;

  logic [CW-1:0]    col_r, col_nxt, col0, col1;
  logic [RW-1:0]    row_r, row_nxt, row0, row1, row2;
  logic             chr_r, chr_nxt, chr0, chr2;
  logic [PIX_W-1:0] held_v_r, held_v_nxt;
  logic [CW-2:0]    pcol;
  logic [RW-1:0]    prow;
  logic             accept;

  // size clamp
  always_comb begin
    if (cfg_out_width == '0) begin
      w_eff = WV_W'(1);
    end else if (32'(cfg_out_width) > 32'(MAX_OUT_WIDTH)) begin
      w_eff = WV_W'(MAX_OUT_WIDTH);
    end else begin
      w_eff = WV_W'(cfg_out_width);
    end
    if (cfg_out_height == '0) begin
      h_eff = HV_W'(1);
    end else if (32'(cfg_out_height) > 32'(MAX_OUT_HEIGHT)) begin
      h_eff = HV_W'(MAX_OUT_HEIGHT);
    end else begin
      h_eff = HV_W'(cfg_out_height);
    end
  end

  assign two_w = {w_eff, 1'b0};
  assign two_h = {h_eff, 1'b0};

  assign in_bus.ready = !q_full;
  assign accept       = in_bus.valid && in_bus.ready;

  // position update for the beat on the bus
  always_comb begin
    col0 = in_bus.frame_start ? '0 : col_r;
    row0 = in_bus.frame_start ? '0 : row_r;
    chr0 = in_bus.frame_start ? 1'b0 : chr_r;
    if (col0 >= two_w) begin
      col1 = '0;
      row1 = row0 + RW'(1);
    end else begin
      col1 = col0;
      row1 = row0;
    end
    if (!chr0 && row1 >= two_h) begin
      row2 = '0;
      chr2 = 1'b1;
    end else if (chr0 && row1 >= RW'(h_eff)) begin
      row2 = '0;
      chr2 = 1'b0;
    end else begin
      row2 = row1;
      chr2 = chr0;
    end
    pcol = col1[CW-1:1];
    prow = chr2 ? row2 : (row2 >> 1);
  end

  always_comb begin
    q_addr = AW'(32'(prow) * MAX_OUT_WIDTH + 32'(pcol));
    q_op.kind = OP_EMIT;
    if (!chr2) begin
      q_op.kind = ((row2[0] | col1[0]) == 1'b0) ? OP_LUMA_SET : OP_LUMA_MAX;
    end
    q_op.data_byte = in_bus.data_byte;
    q_op.chroma_v  = held_v_r;
    q_op.col       = POS_W'(pcol);
    q_op.row       = POS_W'(prow);
    q_op.frame_end = (row2 == RW'(h_eff) - RW'(1)) && (col1 == two_w - CW'(1));
    q_push = accept && (!chr2 || col1[0]);
  end

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    chr_nxt    = chr_r;
    held_v_nxt = held_v_r;
    if (accept) begin
      col_nxt = col1 + CW'(1);
      row_nxt = row2;
      chr_nxt = chr2;
      if (chr2 && !col1[0]) begin
        held_v_nxt = in_bus.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      chr_r    <= 1'b0;
      held_v_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      chr_r    <= chr_nxt;
      held_v_r <= held_v_nxt;
    end
  end

endmodule

// ----- rtl/nmp_fifo.sv -----
// small op queue between front end and pooling back end
`timescale 1ns / 1ps
module nmp_fifo #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output logic              full,
  output logic              empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == NW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/nmp_back.sv -----
// back end: pooled luma store read-modify-write and pixel output register
`timescale 1ns / 1ps
module nmp_back import nmp_pkg::*; #(
  parameter int MAX_OUT_WIDTH  = 512,
  parameter int MAX_OUT_HEIGHT = 512,
  parameter int AW             = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  nmp_op_t       q_op,
  input  logic [AW-1:0] q_addr,
  output logic          q_pop,
  nmp_out_if.source     out_bus
);

  localparam int DEPTH = MAX_OUT_WIDTH * MAX_OUT_HEIGHT;

  logic [PIX_W-1:0] store [DEPTH];

  logic             b_valid_r, b_valid_nxt;
  nmp_op_t          b_op_r;
  logic [AW-1:0]    b_addr_r;
  logic [PIX_W-1:0] rdata_r;
  logic             fwd_hit_r, fwd_hit_nxt;
  logic [PIX_W-1:0] fwd_data_r;
  logic [PIX_W-1:0] old_val, wr_val;
  logic             is_emit, out_free, b_done, b_ready, we;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_luma_r, out_u_r, out_v_r;
  logic [POS_W-1:0] out_col_r, out_row_r;
  logic             out_end_r;

  // write from the stage leaving b on the read edge is forwarded
  assign old_val  = fwd_hit_r ? fwd_data_r : rdata_r;
  assign is_emit  = (b_op_r.kind == OP_EMIT);
  assign out_free = !out_valid_r || out_bus.ready;
  assign b_done   = b_valid_r && (!is_emit || out_free);
  assign b_ready  = !b_valid_r || b_done;
  assign q_pop    = q_valid && b_ready;
  assign we       = b_valid_r && !is_emit;

  always_comb begin
    wr_val = b_op_r.data_byte;
    if (b_op_r.kind == OP_LUMA_MAX && old_val > b_op_r.data_byte) begin
      wr_val = old_val;
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    fwd_hit_nxt = fwd_hit_r;
    if (b_ready) begin
      b_valid_nxt = q_pop;
    end
    if (q_pop) begin
      fwd_hit_nxt = we && (b_addr_r == q_addr);
    end
    out_valid_nxt = out_valid_r;
    if (b_done && is_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      fwd_hit_r   <= fwd_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store[b_addr_r] <= wr_val;
    end
    if (q_pop) begin
      rdata_r <= store[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_op_r     <= q_op;
      b_addr_r   <= q_addr;
      fwd_data_r <= wr_val;
    end
    if (b_done && is_emit) begin
      out_luma_r <= old_val;
      out_u_r    <= b_op_r.data_byte;
      out_v_r    <= b_op_r.chroma_v;
      out_col_r  <= b_op_r.col;
      out_row_r  <= b_op_r.row;
      out_end_r  <= b_op_r.frame_end;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.luma      = out_luma_r;
  assign out_bus.chroma_u  = out_u_r;
  assign out_bus.chroma_v  = out_v_r;
  assign out_bus.out_col   = out_col_r;
  assign out_bus.out_row   = out_row_r;
  assign out_bus.frame_end = out_end_r;

endmodule

// ----- tb/nv21_maxpool_yuv_pack_tb.sv -----
// self-checking testbench of the nv21 max-pool yuv packer: random nv21 frames, pixel checks
`timescale 1ns / 1ps
module nv21_maxpool_yuv_pack_tb;
  import nmp_pkg::*;

  localparam int MAX_W = 512;
  localparam int MAX_H = 512;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [PIX_W-1:0] data_byte;
    logic             frame_start;
  } nv21_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] chroma_v;
    logic [POS_W-1:0] out_col;
    logic [POS_W-1:0] out_row;
    logic             frame_end;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  nmp_in_if in_bus ();
  nmp_out_if out_bus ();

  nv21_maxpool_yuv_pack #(
    .MAX_OUT_WIDTH(MAX_W),
    .MAX_OUT_HEIGHT(MAX_H)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  nv21_beat_t frame_bytes[$];
  pixel_t pending_pixels[$];

  // pooling state
  logic [PIX_W-1:0] pooled_max [0:MAX_W*MAX_H-1];
  int unsigned col_cnt;
  int unsigned row_cnt;
  bit in_chroma;
  logic [PIX_W-1:0] v_hold;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  int send_idle_pct;
  int recv_stall_pct;
  bit pressure_go;
  logic hold_rx;
  int errors;
  int unsigned beats_queued;
  int unsigned cycles;

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] r, input int unsigned hi);
    if (r == 0) return 1;
    if (r > hi) return hi;
    return r;
  endfunction

  task pool_byte(input logic [PIX_W-1:0] b, input logic fs);
    int unsigned w, h, pcol, prow, idx;
    pixel_t px;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
      in_chroma = 1'b0;
    end
    if (col_cnt >= 2 * w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (!in_chroma && row_cnt >= 2 * h) begin
      row_cnt = 0;
      in_chroma = 1'b1;
    end else if (in_chroma && row_cnt >= h) begin
      row_cnt = 0;
      in_chroma = 1'b0;
    end
    pcol = col_cnt >> 1;
    prow = in_chroma ? row_cnt : (row_cnt >> 1);
    idx = prow * MAX_W + pcol;
    if (!in_chroma) begin
      if (((row_cnt | col_cnt) & 1) == 0 || b > pooled_max[idx]) pooled_max[idx] = b;
    end else if ((col_cnt & 1) == 0) begin
      v_hold = b;
    end else begin
      px.luma = pooled_max[idx];
      px.chroma_u = b;
      px.chroma_v = v_hold;
      px.out_col = POS_W'(pcol);
      px.out_row = POS_W'(prow);
      px.frame_end = (row_cnt == h - 1) && (col_cnt == 2 * w - 1);
      pending_pixels.push_back(px);
    end
    col_cnt++;
  endtask

  task note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // input driver
  always @(posedge clk) begin : drive_p
    nv21_beat_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.data_byte <= '0;
      in_bus.frame_start <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) pool_byte(in_bus.data_byte, in_bus.frame_start);
      if (!in_bus.valid || in_bus.ready) begin
        if (frame_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = frame_bytes.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.data_byte <= nxt.data_byte;
          in_bus.frame_start <= nxt.frame_start;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor
  always @(posedge clk) begin : check_p
    pixel_t got, want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.luma = out_bus.luma;
        got.chroma_u = out_bus.chroma_u;
        got.chroma_v = out_bus.chroma_v;
        got.out_col = out_bus.out_col;
        got.out_row = out_bus.out_row;
        got.frame_end = out_bus.frame_end;
        if (pending_pixels.size() == 0) begin
          note_error($sformatf("unexpected pixel y=%0d u=%0d v=%0d col=%0d row=%0d end=%0b",
                               got.luma, got.chroma_u, got.chroma_v, got.out_col,
                               got.out_row, got.frame_end));
        end else begin
          want = pending_pixels.pop_front();
          if (got.luma !== want.luma || got.chroma_u !== want.chroma_u ||
              got.chroma_v !== want.chroma_v || got.out_col !== want.out_col ||
              got.out_row !== want.out_row || got.frame_end !== want.frame_end) begin
            note_error({
              $sformatf("pixel mismatch: got y=%0d u=%0d v=%0d col=%0d row=%0d end=%0b, ",
                        got.luma, got.chroma_u, got.chroma_v, got.out_col, got.out_row,
                        got.frame_end),
              $sformatf("want y=%0d u=%0d v=%0d col=%0d row=%0d end=%0b",
                        want.luma, want.chroma_u, want.chroma_v, want.out_col,
                        want.out_row, want.frame_end)});
          end
        end
      end
      out_bus.ready <= !hold_rx && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off to back up the pipe
  initial begin : rx_hold_p
    hold_rx = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task push_beat(input logic [PIX_W-1:0] b, input logic fs);
    nv21_beat_t nb;
    nb.data_byte = b;
    nb.frame_start = fs;
    frame_bytes.push_back(nb);
    beats_queued++;
  endtask

  task queue_frame(input bit with_start, input bit cut_short);
    int unsigned total, count, i;
    logic [PIX_W-1:0] val;
    total = 6 * eff_size(width_reg, MAX_W) * eff_size(height_reg, MAX_H);
    count = cut_short ? $urandom_range(1, total - 1) : total;
    @(negedge clk);
    for (i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: val = '0;
        1: val = '1;
        default: val = PIX_W'($urandom_range(0, 255));
      endcase
      push_beat(val, with_start && i == 0);
    end
  endtask

  task drain();
    while (frame_bytes.size() != 0 || in_bus.valid || pending_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task cfg_write(input logic sel, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task set_sizes(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    drain();
    cfg_write(REG_OUT_WIDTH, 32'(w));
    cfg_write(REG_OUT_HEIGHT, 32'(h));
    width_reg = w;
    height_reg = h;
  endtask

  initial begin : stim_p
    int phase;
    int unsigned phase_start;
    bit frame_open;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    in_bus.frame_start = 1'b0;
    out_bus.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pressure_go = 1'b0;
    errors = 0;
    beats_queued = 0;
    cycles = 0;
    col_cnt = 0;
    row_cnt = 0;
    in_chroma = 1'b0;
    v_hold = '0;
    width_reg = OUT_WIDTH_RST;
    height_reg = OUT_HEIGHT_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // zero sizes act as one: 2x2 luma block then one v,u pair
    set_sizes('0, '0);
    @(negedge clk);
    push_beat(8'hff, 1'b1);
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hff, 1'b0);
    // next frame runs on without frame_start
    push_beat(8'h00, 1'b0);
    push_beat(8'h7f, 1'b0);
    push_beat(8'h80, 1'b0);
    push_beat(8'h01, 1'b0);
    push_beat(8'hff, 1'b0);
    push_beat(8'h00, 1'b0);
    // frame cut short by a new frame_start
    push_beat(8'h12, 1'b1);
    push_beat(8'h34, 1'b0);
    push_beat(8'h56, 1'b0);
    push_beat(8'h01, 1'b1);
    push_beat(8'h02, 1'b0);
    push_beat(8'h03, 1'b0);
    push_beat(8'hfe, 1'b0);
    push_beat(8'h5a, 1'b0);
    push_beat(8'ha5, 1'b0);

    for (phase = 0; phase < 4; phase++) begin
      drain();
      @(negedge clk);
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct = 14;
          recv_stall_pct = 14;
        end
      endcase
      phase_start = beats_queued;
      while (beats_queued - phase_start < 260) begin
        set_sizes(SIZE_W'($urandom_range(0, 6)), SIZE_W'($urandom_range(0, 4)));
        frame_open = 1'b1;
        if (phase == 0 && !pressure_go) begin
          @(negedge clk);
          pressure_go = 1'b1;
        end
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 6) == 0) begin
            queue_frame(1'b1, 1'b1);
            frame_open = 1'b1;
          end else begin
            queue_frame(frame_open || $urandom_range(0, 1), 1'b0);
            frame_open = 1'b0;
          end
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/nmp_pkg.sv
rtl/nmp_if.sv
rtl/nmp_front.sv
rtl/nmp_fifo.sv
rtl/nmp_back.sv
rtl/nv21_maxpool_yuv_pack.sv
tb/nv21_maxpool_yuv_pack_tb.sv
